// File: rtl/core/mail_address_header_split_defines.svh
// ----------------------------------------------------------------------------
// mail_address_header_split_defines: assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef MAIL_ADDRESS_HEADER_SPLIT_DEFINES_SVH
`define MAIL_ADDRESS_HEADER_SPLIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every edge outside reset
`define MAHS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// overlapping implication
`define MAHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);
`else
`define MAHS_ASSERT(label, clk, rst_n, prop, msg)
`define MAHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/mahs_pkg.sv
// ----------------------------------------------------------------------------
// mahs_pkg: shared types and constants
// Character codes, byte class flags and result codes of the header splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package mahs_pkg;

    // commands
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FETCH  = 1'b1;

    // result status
    localparam logic [1:0] STATUS_BYTE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_NONE  = 2'd2;

    // result part
    localparam logic PART_NAME = 1'b0;
    localparam logic PART_ADDR = 1'b1;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;

    // byte classes
    typedef struct packed {
        logic zero;     // string terminator
        logic lt;
        logic gt;
        logic lp;
        logic rp;
        logic ws;       // tab..cr or space
        logic ctrl;     // below space
        logic le_space; // at or below space
    } t_cls;

endpackage

`default_nettype wire

// File: rtl/core/mahs_classify.sv
// ----------------------------------------------------------------------------
// mahs_classify: byte classifier
// Shared compare unit: flags delimiters, whitespace and control bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mahs_classify (
    input  wire logic [7:0]     i_byte,
    output mahs_pkg::t_cls      o_cls
);

    always_comb begin
        o_cls.zero     = (i_byte == mahs_pkg::CH_NUL);
        o_cls.lt       = (i_byte == mahs_pkg::CH_LT);
        o_cls.gt       = (i_byte == mahs_pkg::CH_GT);
        o_cls.lp       = (i_byte == mahs_pkg::CH_LP);
        o_cls.rp       = (i_byte == mahs_pkg::CH_RP);
        o_cls.ws       = i_byte inside {[mahs_pkg::CH_TAB:mahs_pkg::CH_CR], mahs_pkg::CH_SPACE};
        o_cls.ctrl     = (i_byte < mahs_pkg::CH_SPACE);
        o_cls.le_space = (i_byte <= mahs_pkg::CH_SPACE);
    end

endmodule

`default_nettype wire

// File: rtl/core/mail_address_header_split.sv
// ----------------------------------------------------------------------------
// mail_address_header_split: From-style header splitter
// Items arrive on the input channel (i_in_valid / o_in_stall). An append item
// (cmd 0) stores one header byte; bytes past TEXT_DEPTH are dropped
// and flag overflow. The append marked last starts the split: a sequencer
// makes up to three passes over the text memory (delimiter scan, name trim,
// address copy), one byte a cycle through the text memory's read port and
// the shared byte classifier, with the input stalled meanwhile. A fetch item
// (cmd 1) yields one result item on the output channel (o_out_valid /
// i_out_stall): the fetch state registers the read of the text or address
// memory, then the result register takes the byte or marker; the input stalls
// in the fetch state, so a new item is taken only once the result is registered.
// Real name bytes come first, then address bytes, an empty marker for an
// empty part, status 2 when nothing is pending. A result waits in the output
// register while the receiver stalls, and every further item, append or
// fetch, waits with it.
// Reset (synchronous, active low) empties both stores and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mail_address_header_split_defines.svh"

module mail_address_header_split #(
    parameter int TEXT_DEPTH = 1024,
    parameter int ADDR_MAX   = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic             o_part,
    output logic [7:0]       o_out_byte,
    output logic             o_last_in_part,
    output logic             o_overflowed
);

    // widths: index and count of each store, shared read pointer
    localparam int TW  = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int TCW = $clog2(TEXT_DEPTH + 1);
    localparam int AW  = (ADDR_MAX > 1) ? $clog2(ADDR_MAX) : 1;
    localparam int ACW = $clog2(ADDR_MAX + 1);
    localparam int RIW = (TCW > ACW) ? TCW : ACW;

    localparam logic [TCW-1:0] TEXT_DEPTH_C = TCW'(TEXT_DEPTH);
    localparam logic [ACW-1:0] ADDR_MAX_C   = ACW'(ADDR_MAX);

    // sequencer
    typedef enum logic [2:0] {
        S_IDLE,   // taking items
        S_FETCH,  // memory read in flight for a result
        S_SCAN,   // find terminator, '<', '(' and ')'
        S_NAME,   // trim the real name span
        S_ADDR    // copy the address
    } t_state;

    // result stream position
    typedef enum logic [1:0] {
        PH_LOAD,
        PH_NAME,
        PH_ADDR,
        PH_DONE
    } t_phase;

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;

    logic [TCW-1:0]     r_text_count, n_text_count;
    logic [ACW-1:0]     r_addr_count, n_addr_count;
    logic [TCW-1:0]     r_name_begin, n_name_begin;
    logic [TCW-1:0]     r_name_end,   n_name_end;
    logic [RIW-1:0]     r_read_index, n_read_index;
    logic               r_ovf,        n_ovf;

    // scan engine: issue pointer, limit, data in flight
    logic [TCW-1:0]     r_ptr,  n_ptr;
    logic [TCW-1:0]     r_lim,  n_lim;
    logic               r_dv,   n_dv;
    logic [TCW-1:0]     r_didx, n_didx;

    // delimiter positions
    logic [TCW-1:0]     r_n,  n_n;
    logic               r_lt_f, n_lt_f;
    logic [TCW-1:0]     r_lt, n_lt;
    logic               r_lp_f, n_lp_f;
    logic [TCW-1:0]     r_lp, n_lp;
    logic               r_rp_f, n_rp_f;
    logic [TCW-1:0]     r_rp, n_rp;
    logic               r_nb_f, n_nb_f;
    logic               r_angle, n_angle;
    logic               r_inword, n_inword;

    // result register
    logic               r_out_valid,  n_out_valid;
    logic [1:0]         r_status,     n_status;
    logic               r_part,       n_part;
    logic [7:0]         r_out_byte,   n_out_byte;
    logic               r_last,       n_last;
    logic               r_ovf_out,    n_ovf_out;
    logic               r_fetch_byte, n_fetch_byte;
    logic               r_fetch_src,  n_fetch_src;

    // memories
    logic [7:0]         mem_text [0:TEXT_DEPTH-1];
    logic [7:0]         mem_addr [0:ADDR_MAX-1];
    logic [7:0]         r_text_rdata;
    logic [7:0]         r_addr_rdata;

    logic               text_we, text_re;
    logic [TW-1:0]      text_waddr, text_raddr;
    logic [7:0]         text_wdata;
    logic               addr_we, addr_re;
    logic [AW-1:0]      addr_waddr, addr_raddr;
    logic [7:0]         addr_wdata;

    logic               in_acc;
    mahs_pkg::t_cls     cls;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_part         = r_part;
    assign o_out_byte     = r_out_byte;
    assign o_last_in_part = r_last;
    assign o_overflowed   = r_ovf_out;

    // every pass looks at the byte just read from the text memory
    mahs_classify u_classify (
        .i_byte (r_text_rdata),
        .o_cls  (cls)
    );

    always_comb begin
        logic [TCW-1:0] base;
        logic [TCW-1:0] from;
        logic [TCW-1:0] to;
        logic           issue;
        logic           pass_end;
        logic           stop;
        logic           fin;
        logic           store;

        n_state      = r_state;
        n_phase      = r_phase;
        n_text_count = r_text_count;
        n_addr_count = r_addr_count;
        n_name_begin = r_name_begin;
        n_name_end   = r_name_end;
        n_read_index = r_read_index;
        n_ovf        = r_ovf;
        n_ptr        = r_ptr;
        n_lim        = r_lim;
        n_dv         = 1'b0;
        n_didx       = r_didx;
        n_n          = r_n;
        n_lt_f       = r_lt_f;
        n_lt         = r_lt;
        n_lp_f       = r_lp_f;
        n_lp         = r_lp;
        n_rp_f       = r_rp_f;
        n_rp         = r_rp;
        n_nb_f       = r_nb_f;
        n_angle      = r_angle;
        n_inword     = r_inword;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_part       = r_part;
        n_out_byte   = r_out_byte;
        n_last       = r_last;
        n_ovf_out    = r_ovf_out;
        n_fetch_byte = r_fetch_byte;
        n_fetch_src  = r_fetch_src;

        text_we    = 1'b0;
        text_waddr = r_text_count[TW-1:0];
        text_wdata = i_in_byte;
        text_re    = 1'b0;
        text_raddr = r_ptr[TW-1:0];
        addr_we    = 1'b0;
        addr_waddr = r_addr_count[AW-1:0];
        addr_wdata = r_text_rdata;
        addr_re    = 1'b0;
        addr_raddr = r_read_index[AW-1:0];

        base     = r_text_count;
        from     = '0;
        to       = '0;
        issue    = (r_ptr < r_lim);
        pass_end = !r_dv && !issue;
        stop     = 1'b0;
        fin      = 1'b0;
        store    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == mahs_pkg::CMD_APPEND)) begin
                    // first append after a split starts a fresh header
                    if (r_phase != PH_LOAD) begin
                        base         = '0;
                        n_ovf        = 1'b0;
                        n_addr_count = '0;
                        n_phase      = PH_LOAD;
                    end
                    if (base < TEXT_DEPTH_C) begin
                        text_we      = 1'b1;
                        text_waddr   = base[TW-1:0];
                        n_text_count = base + 1'b1;
                    end else begin
                        n_ovf        = 1'b1;
                        n_text_count = base;
                    end
                    if (i_in_last) begin
                        n_state = S_SCAN;
                        n_ptr   = '0;
                        n_lim   = n_text_count;
                        n_n     = n_text_count;
                        n_lt_f  = 1'b0;
                        n_lp_f  = 1'b0;
                        n_rp_f  = 1'b0;
                    end
                end else if (in_acc) begin
                    n_state      = S_FETCH;
                    n_ovf_out    = r_ovf;
                    n_status     = mahs_pkg::STATUS_NONE;
                    n_part       = mahs_pkg::PART_NAME;
                    n_last       = 1'b0;
                    n_fetch_byte = 1'b0;
                    n_fetch_src  = 1'b0;
                    case (r_phase)
                        PH_NAME: begin
                            n_last = 1'b1;
                            if ((r_name_end <= r_name_begin) ||
                                (r_read_index >= RIW'(r_name_end)) ||
                                (r_read_index >= RIW'(TEXT_DEPTH_C))) begin
                                n_status     = mahs_pkg::STATUS_EMPTY;
                                n_phase      = PH_ADDR;
                                n_read_index = '0;
                            end else begin
                                n_status     = mahs_pkg::STATUS_BYTE;
                                n_fetch_byte = 1'b1;
                                text_re      = 1'b1;
                                text_raddr   = r_read_index[TW-1:0];
                                n_read_index = r_read_index + 1'b1;
                                if (n_read_index >= RIW'(r_name_end)) begin
                                    n_phase      = PH_ADDR;
                                    n_read_index = '0;
                                end else begin
                                    n_last = 1'b0;
                                end
                            end
                        end
                        PH_ADDR: begin
                            n_part = mahs_pkg::PART_ADDR;
                            n_last = 1'b1;
                            if ((r_addr_count == '0) ||
                                (r_read_index >= RIW'(r_addr_count)) ||
                                (r_read_index >= RIW'(ADDR_MAX_C))) begin
                                n_status = mahs_pkg::STATUS_EMPTY;
                                n_phase  = PH_DONE;
                            end else begin
                                n_status     = mahs_pkg::STATUS_BYTE;
                                n_fetch_byte = 1'b1;
                                n_fetch_src  = 1'b1;
                                addr_re      = 1'b1;
                                addr_raddr   = r_read_index[AW-1:0];
                                n_read_index = r_read_index + 1'b1;
                                if (n_read_index >= RIW'(r_addr_count)) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_last = 1'b0;
                                end
                            end
                        end
                        default: begin
                            // loading or both parts sent: nothing pending
                        end
                    endcase
                end
            end

            S_FETCH: begin
                n_out_valid = 1'b1;
                if (r_fetch_byte) begin
                    n_out_byte = r_fetch_src ? r_addr_rdata : r_text_rdata;
                end else begin
                    n_out_byte = 8'h00;
                end
                n_state = S_IDLE;
            end

            S_SCAN: begin
                if (issue) begin
                    text_re = 1'b1;
                    n_dv    = 1'b1;
                    n_didx  = r_ptr;
                    n_ptr   = r_ptr + 1'b1;
                end
                if (r_dv) begin
                    if (cls.zero) begin
                        stop = 1'b1;
                        n_n  = r_didx;
                    end else begin
                        if (cls.lt && !r_lt_f) begin
                            n_lt_f = 1'b1;
                            n_lt   = r_didx;
                        end
                        if (cls.lp && !r_lp_f) begin
                            n_lp_f = 1'b1;
                            n_lp   = r_didx;
                        end
                        // only a ')' after the first '('
                        if (cls.rp && r_lp_f && !r_rp_f) begin
                            n_rp_f = 1'b1;
                            n_rp   = r_didx;
                        end
                    end
                end
                if (stop || pass_end) begin
                    n_dv = 1'b0;
                    if (r_lt_f) begin
                        from    = '0;
                        to      = r_lt;
                        n_angle = 1'b1;
                    end else if (r_lp_f && r_rp_f) begin
                        from    = r_lp + 1'b1;
                        to      = r_rp;
                        n_angle = 1'b0;
                    end else begin
                        from    = '0;
                        to      = '0;
                        n_angle = 1'b0;
                    end
                    n_ptr        = from;
                    n_lim        = to;
                    n_name_begin = to;
                    n_name_end   = to;
                    n_nb_f       = 1'b0;
                    n_state      = S_NAME;
                end
            end

            S_NAME: begin
                if (issue) begin
                    text_re = 1'b1;
                    n_dv    = 1'b1;
                    n_didx  = r_ptr;
                    n_ptr   = r_ptr + 1'b1;
                end
                if (r_dv && !cls.ws) begin
                    if (!r_nb_f) begin
                        n_nb_f       = 1'b1;
                        n_name_begin = r_didx;
                    end
                    n_name_end = r_didx + 1'b1;
                end
                if (pass_end) begin
                    n_state      = S_ADDR;
                    n_addr_count = '0;
                    n_inword     = 1'b0;
                    n_ptr        = r_angle ? (r_lt + 1'b1) : '0;
                    n_lim        = r_n;
                end
            end

            S_ADDR: begin
                if (issue) begin
                    text_re = 1'b1;
                    n_dv    = 1'b1;
                    n_didx  = r_ptr;
                    n_ptr   = r_ptr + 1'b1;
                end
                if (r_dv) begin
                    if (r_angle) begin
                        // bracketed: up to '>', control bytes dropped
                        if (cls.gt) begin
                            fin = 1'b1;
                        end else if (!cls.ctrl) begin
                            if (r_addr_count >= ADDR_MAX_C) begin
                                fin = 1'b1;
                            end else begin
                                store = 1'b1;
                            end
                        end
                    end else begin
                        // bare: first word above space
                        if (cls.le_space) begin
                            if (r_inword) begin
                                fin = 1'b1;
                            end
                        end else begin
                            n_inword = 1'b1;
                            if (r_addr_count >= ADDR_MAX_C) begin
                                fin = 1'b1;
                            end else begin
                                store = 1'b1;
                            end
                        end
                    end
                end
                if (store) begin
                    addr_we      = 1'b1;
                    addr_waddr   = r_addr_count[AW-1:0];
                    addr_wdata   = r_text_rdata;
                    n_addr_count = r_addr_count + 1'b1;
                end
                if (pass_end) begin
                    fin = 1'b1;
                    // bracket never closed and not truncated: no address
                    if (r_angle) begin
                        n_addr_count = '0;
                    end
                end
                if (fin) begin
                    n_dv         = 1'b0;
                    n_state      = S_IDLE;
                    n_phase      = PH_NAME;
                    n_read_index = RIW'(r_name_begin);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_LOAD;
            r_text_count <= '0;
            r_addr_count <= '0;
            r_name_begin <= '0;
            r_name_end   <= '0;
            r_read_index <= '0;
            r_ovf        <= 1'b0;
            r_ptr        <= '0;
            r_lim        <= '0;
            r_dv         <= 1'b0;
            r_lt_f       <= 1'b0;
            r_lp_f       <= 1'b0;
            r_rp_f       <= 1'b0;
            r_nb_f       <= 1'b0;
            r_angle      <= 1'b0;
            r_inword     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fetch_byte <= 1'b0;
            r_fetch_src  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_text_count <= n_text_count;
            r_addr_count <= n_addr_count;
            r_name_begin <= n_name_begin;
            r_name_end   <= n_name_end;
            r_read_index <= n_read_index;
            r_ovf        <= n_ovf;
            r_ptr        <= n_ptr;
            r_lim        <= n_lim;
            r_dv         <= n_dv;
            r_lt_f       <= n_lt_f;
            r_lp_f       <= n_lp_f;
            r_rp_f       <= n_rp_f;
            r_nb_f       <= n_nb_f;
            r_angle      <= n_angle;
            r_inword     <= n_inword;
            r_out_valid  <= n_out_valid;
            r_fetch_byte <= n_fetch_byte;
            r_fetch_src  <= n_fetch_src;
        end
        // payload, no reset
        r_didx     <= n_didx;
        r_n        <= n_n;
        r_lt       <= n_lt;
        r_lp       <= n_lp;
        r_rp       <= n_rp;
        r_status   <= n_status;
        r_part     <= n_part;
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
        r_ovf_out  <= n_ovf_out;
    end

    // header text
    always_ff @(posedge i_clk) begin
        if (text_we) begin
            mem_text[text_waddr] <= text_wdata;
        end
        if (text_re) begin
            r_text_rdata <= mem_text[text_raddr];
        end
    end

    // extracted address
    always_ff @(posedge i_clk) begin
        if (addr_we) begin
            mem_addr[addr_waddr] <= addr_wdata;
        end
        if (addr_re) begin
            r_addr_rdata <= mem_addr[addr_raddr];
        end
    end

    // ---- assertions ----
    `MAHS_ASSERT(a_addr_bound, i_clk, i_rst_n, r_addr_count <= ADDR_MAX_C,
                 "address count past limit")
    `MAHS_ASSERT(a_name_span, i_clk, i_rst_n, r_name_end >= r_name_begin,
                 "name span inverted")
    `MAHS_ASSERT_IMP(a_fetch_lat, i_clk, i_rst_n,
                     in_acc && (i_cmd == mahs_pkg::CMD_FETCH), ##2 r_out_valid,
                     "fetch result late")
    `MAHS_ASSERT_IMP(a_nobyte_zero, i_clk, i_rst_n,
                     r_out_valid && (r_status != mahs_pkg::STATUS_BYTE),
                     r_out_byte == 8'h00, "marker carries a byte")

endmodule

`default_nettype wire
